[hdl/cbb_pkg.sv]
// circle_box_bounce shared package: fixed-point constants, register indexes, helpers
// depends on nothing
package cbb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int RAD_W         = 31;
  localparam int CFG_ADDR_W    = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_CX   = 3'd0,
    REG_BOX_CY   = 3'd1,
    REG_BOX_W    = 3'd2,
    REG_BOX_H    = 3'd3,
    REG_PADDLE   = 3'd4
  } cfg_reg_t;

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) begin
      sat34 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat34 = 32'sh80000000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat66 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat66 = 32'sh80000000;
    end else begin
      sat66 = v[31:0];
    end
  endfunction

endpackage

[hdl/cbb_div.sv]
// cbb_div: pipelined restoring divider, one quotient bit per stage
// depends on cbb_pkg; forward-only pipeline, payload of width PW rides alongside
module cbb_div import cbb_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 62,
  parameter int QW = 80,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  // numerator is shifted in MSB first, then QW-NW zero bits
  logic [QW:1]     vld_r;
  logic [DW:0]     rem_r [1:QW-1];
  logic [QW-1:0]   quo_r [1:QW];
  logic [QW-1:0]   num_r [1:QW-1];
  logic [DW-1:0]   den_r [1:QW-1];
  logic [PW-1:0]   pay_r [1:QW];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QW-1:1], in_vld};
    end
  end

  // one restoring step per stage
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   rem_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [DW+1:0] trial;
    logic [DW+1:0] diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = {in_num, {(QW-NW){1'b0}}};
      assign den_in = in_den;
      assign pay_in = in_pay;
    end else begin : g_next
      assign rem_in = rem_r[s];
      assign quo_in = quo_r[s];
      assign num_in = num_r[s];
      assign den_in = den_r[s];
      assign pay_in = pay_r[s];
    end

    always_comb begin
      trial = {rem_in, num_in[QW-1]};
      diff  = trial - {2'b00, den_in};
    end

    always_ff @(posedge clk) begin
      quo_r[s+1] <= {quo_in[QW-2:0], ~diff[DW+1]};
      pay_r[s+1] <= pay_in;
    end

    // remainder, numerator and divisor are not needed after the last step
    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (diff[DW+1]) begin
          rem_r[s+1] <= trial[DW:0];
        end else begin
          rem_r[s+1] <= diff[DW:0];
        end
        num_r[s+1] <= {num_in[QW-2:0], 1'b0};
        den_r[s+1] <= den_in;
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = quo_r[QW];
  assign out_pay = pay_r[QW];

endmodule

[hdl/circle_box_bounce.sv]
// circle_box_bounce: circle against axis-aligned box, collision response
// depends on cbb_pkg and cbb_div
// from start to out_strobe a word passes stages 1 to 6, the divider pipeline (one
// quotient bit per stage), stages 7 and 8 and the output register. throughput: one word
// per cycle, busy never rises. the receiver cannot stall: every result shows for one cycle.
// reset: synchronous active low rst_n clears the config registers to 0 and the valids.
module circle_box_bounce import cbb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_ball_x,
  input  logic signed [31:0]    in_ball_y,
  input  logic signed [31:0]    in_ball_vx,
  input  logic signed [31:0]    in_ball_vy,
  input  logic [RAD_W-1:0]      in_ball_radius,
  input  logic signed [31:0]    in_paddle_vx,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  out_strobe,
  output logic signed [31:0]    out_new_x,
  output logic signed [31:0]    out_new_y,
  output logic signed [31:0]    out_new_vx,
  output logic signed [31:0]    out_new_vy,
  output logic                  out_hit
);

  localparam int QW = 64 + FRAC_BITS + 1;
  // payload through the divider: bx by vx vy dx dy qneg cor_hit hit fx fy fvx fvy pvx
  localparam int PW = 32*4 + 33*2 + 1 + 1 + 1 + 32*4 + 32;

  // payload field offsets, least significant first
  localparam int P_PVX  = 0;
  localparam int P_FVY  = 32;
  localparam int P_FVX  = 64;
  localparam int P_FY   = 96;
  localparam int P_FX   = 128;
  localparam int P_HIT  = 160;
  localparam int P_COR  = 161;
  localparam int P_QNEG = 162;
  localparam int P_DY   = 163;
  localparam int P_DX   = 196;
  localparam int P_VY   = 229;
  localparam int P_VX   = 261;
  localparam int P_BY   = 293;
  localparam int P_BX   = 325;

  // configuration registers
  logic signed [31:0] box_cx_r, box_cy_r;
  logic [30:0]        box_w_r, box_h_r;
  logic               paddle_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_cx_r <= '0;
      box_cy_r <= '0;
      box_w_r  <= '0;
      box_h_r  <= '0;
      paddle_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_CX: box_cx_r <= cfg_data;
        REG_BOX_CY: box_cy_r <= cfg_data;
        REG_BOX_W:  box_w_r  <= cfg_data[30:0];
        REG_BOX_H:  box_h_r  <= cfg_data[30:0];
        REG_PADDLE: paddle_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: register input word, compute box edges
  logic               s1_vld_r;
  logic signed [31:0] s1_bx_r, s1_by_r, s1_vx_r, s1_vy_r, s1_pvx_r;
  logic signed [32:0] s1_r_r;
  logic signed [32:0] s1_x1_r, s1_x2_r, s1_y1_r, s1_y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_bx_r  <= in_ball_x;
    s1_by_r  <= in_ball_y;
    s1_vx_r  <= in_ball_vx;
    s1_vy_r  <= in_ball_vy;
    s1_pvx_r <= in_paddle_vx;
    s1_r_r   <= {2'b00, in_ball_radius};
    s1_x1_r  <= 33'(box_cx_r) - 33'({2'b00, box_w_r[30:1]});
    s1_x2_r  <= 33'(box_cx_r) + 33'({2'b00, box_w_r[30:1]});
    s1_y1_r  <= 33'(box_cy_r) + 33'({2'b00, box_h_r[30:1]});
    s1_y2_r  <= 33'(box_cy_r) - 33'({2'b00, box_h_r[30:1]});
  end

  // stage 2: face tests, corner deltas
  logic               s2_vld_r;
  logic signed [31:0] s2_bx_r, s2_by_r, s2_vx_r, s2_vy_r, s2_pvx_r;
  logic signed [32:0] s2_r_r;
  logic               s2_face_hit_r, s2_face_r;
  logic signed [31:0] s2_fx_r, s2_fy_r, s2_fvx_r, s2_fvy_r;
  logic signed [33:0] s2_dx_r [4];
  logic signed [33:0] s2_dy_r [4];

  logic signed [33:0] bx34, by34, r34, x1, x2, y1, y2;
  logic               in_x, in_y, f_hit;
  logic signed [31:0] f_x, f_y, f_vx, f_vy;

  always_comb begin
    bx34 = 34'(s1_bx_r);
    by34 = 34'(s1_by_r);
    r34  = 34'(s1_r_r);
    x1 = 34'(s1_x1_r);
    x2 = 34'(s1_x2_r);
    y1 = 34'(s1_y1_r);
    y2 = 34'(s1_y2_r);
    in_x = (bx34 >= x1) && (bx34 <= x2);
    in_y = (by34 >= y2) && (by34 <= y1);
    f_hit = 1'b0;
    f_x  = s1_bx_r;
    f_y  = s1_by_r;
    f_vx = s1_vx_r;
    f_vy = s1_vy_r;
    if (in_x) begin
      if (by34 < y2 && by34 > y2 - r34) begin
        f_y = sat34(y2 - r34);
        f_vy = sat34(-34'(s1_vy_r));
        f_hit = 1'b1;
      end else if (by34 > y1 && by34 < y1 + r34) begin
        f_y = sat34(y1 + r34);
        f_vy = sat34(-34'(s1_vy_r));
        f_hit = 1'b1;
      end
    end else if (in_y) begin
      if (bx34 < x1 && bx34 > x1 - r34) begin
        f_x = sat34(x1 - r34);
        f_vx = sat34(-34'(s1_vx_r));
        f_hit = 1'b1;
      end else if (bx34 > x2 && bx34 < x2 + r34) begin
        f_x = sat34(x2 + r34);
        f_vx = sat34(-34'(s1_vx_r));
        f_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_bx_r  <= s1_bx_r;
    s2_by_r  <= s1_by_r;
    s2_vx_r  <= s1_vx_r;
    s2_vy_r  <= s1_vy_r;
    s2_pvx_r <= s1_pvx_r;
    s2_r_r   <= s1_r_r;
    s2_face_r     <= in_x || in_y;
    s2_face_hit_r <= f_hit;
    s2_fx_r  <= f_x;
    s2_fy_r  <= f_y;
    s2_fvx_r <= f_vx;
    s2_fvy_r <= f_vy;
    // corners: top-left, top-right, bottom-left, bottom-right
    s2_dx_r[0] <= bx34 - x1;
    s2_dy_r[0] <= by34 - y1;
    s2_dx_r[1] <= bx34 - x2;
    s2_dy_r[1] <= by34 - y1;
    s2_dx_r[2] <= bx34 - x1;
    s2_dy_r[2] <= by34 - y2;
    s2_dx_r[3] <= bx34 - x2;
    s2_dy_r[3] <= by34 - y2;
  end

  // stage 3: squares of deltas and r^2 (magnitudes below r fit 31 bits)
  logic               s3_vld_r;
  logic signed [31:0] s3_bx_r, s3_by_r, s3_vx_r, s3_vy_r, s3_pvx_r;
  logic               s3_face_hit_r, s3_face_r;
  logic signed [31:0] s3_fx_r, s3_fy_r, s3_fvx_r, s3_fvy_r;
  logic [61:0]        s3_r2_r;
  logic [3:0]         s3_near_r;
  logic [61:0]        s3_sqx_r [4];
  logic [61:0]        s3_sqy_r [4];
  logic signed [33:0] s3_dx_r [4];
  logic signed [33:0] s3_dy_r [4];

  for (genvar c = 0; c < 4; c++) begin : g_sq
    logic [33:0] adx, ady;
    always_comb begin
      adx = s2_dx_r[c][33] ? 34'(-s2_dx_r[c]) : 34'(s2_dx_r[c]);
      ady = s2_dy_r[c][33] ? 34'(-s2_dy_r[c]) : 34'(s2_dy_r[c]);
    end
    always_ff @(posedge clk) begin
      s3_near_r[c] <= (adx < 34'(s2_r_r)) && (ady < 34'(s2_r_r));
      s3_sqx_r[c]  <= adx[30:0] * adx[30:0];
      s3_sqy_r[c]  <= ady[30:0] * ady[30:0];
      s3_dx_r[c]   <= s2_dx_r[c];
      s3_dy_r[c]   <= s2_dy_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_bx_r  <= s2_bx_r;
    s3_by_r  <= s2_by_r;
    s3_vx_r  <= s2_vx_r;
    s3_vy_r  <= s2_vy_r;
    s3_pvx_r <= s2_pvx_r;
    s3_face_r     <= s2_face_r;
    s3_face_hit_r <= s2_face_hit_r;
    s3_fx_r  <= s2_fx_r;
    s3_fy_r  <= s2_fy_r;
    s3_fvx_r <= s2_fvx_r;
    s3_fvy_r <= s2_fvy_r;
    s3_r2_r  <= s2_r_r[30:0] * s2_r_r[30:0];
  end

  // stage 4: pick first corner inside the radius
  logic               s4_vld_r;
  logic signed [31:0] s4_bx_r, s4_by_r, s4_vx_r, s4_vy_r, s4_pvx_r;
  logic               s4_hit_r, s4_cor_r;
  logic signed [31:0] s4_fx_r, s4_fy_r, s4_fvx_r, s4_fvy_r;
  logic [61:0]        s4_r2_r;
  logic signed [32:0] s4_dx_r, s4_dy_r;

  logic [3:0]         in_rad;
  logic               c_hit;
  logic signed [33:0] c_dx, c_dy;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      in_rad[c] = s3_near_r[c] && (63'(s3_sqx_r[c]) + 63'(s3_sqy_r[c]) < 63'(s3_r2_r));
    end
    c_hit = 1'b0;
    c_dx  = s3_dx_r[0];
    c_dy  = s3_dy_r[0];
    priority if (in_rad[0]) begin
      c_hit = 1'b1;
    end else if (in_rad[1]) begin
      c_hit = 1'b1; c_dx = s3_dx_r[1]; c_dy = s3_dy_r[1];
    end else if (in_rad[2]) begin
      c_hit = 1'b1; c_dx = s3_dx_r[2]; c_dy = s3_dy_r[2];
    end else if (in_rad[3]) begin
      c_hit = 1'b1; c_dx = s3_dx_r[3]; c_dy = s3_dy_r[3];
    end else begin
      c_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_bx_r  <= s3_bx_r;
    s4_by_r  <= s3_by_r;
    s4_vx_r  <= s3_vx_r;
    s4_vy_r  <= s3_vy_r;
    s4_pvx_r <= s3_pvx_r;
    s4_cor_r <= !s3_face_r && c_hit;
    s4_hit_r <= s3_face_r ? s3_face_hit_r : c_hit;
    s4_fx_r  <= s3_fx_r;
    s4_fy_r  <= s3_fy_r;
    s4_fvx_r <= s3_fvx_r;
    s4_fvy_r <= s3_fvy_r;
    s4_r2_r  <= s3_r2_r;
    s4_dx_r  <= c_dx[32:0];
    s4_dy_r  <= c_dy[32:0];
  end

  // stage 5: products of the dot, d magnitude below r so 32 bits suffice
  logic               s5_vld_r;
  logic [PW-1:0]      s5_pay_r;
  logic signed [63:0] s5_px_r, s5_py_r;
  logic [61:0]        s5_r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_px_r  <= s4_vx_r * $signed(s4_dx_r[31:0]);
    s5_py_r  <= s4_vy_r * $signed(s4_dy_r[31:0]);
    s5_r2_r  <= (s4_r2_r == '0) ? 62'd1 : s4_r2_r;
    s5_pay_r <= {s4_bx_r, s4_by_r, s4_vx_r, s4_vy_r, s4_dx_r, s4_dy_r, 1'b0,
                 s4_cor_r, s4_hit_r, s4_fx_r, s4_fy_r, s4_fvx_r, s4_fvy_r, s4_pvx_r};
  end

  // stage 6: dot product magnitude and sign
  logic               s6_vld_r;
  logic [PW-1:0]      s6_pay_r;
  logic [63:0]        s6_a_r;
  logic [61:0]        s6_r2_r;
  logic signed [64:0] dot;

  always_comb begin
    dot = 65'(s5_px_r) + 65'(s5_py_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_a_r   <= dot[64] ? 64'(-dot) : 64'(dot);
    s6_r2_r  <= s5_r2_r;
    s6_pay_r <= {s5_pay_r[PW-1:PW-194], (dot > 65'sd0), s5_pay_r[PW-196:0]};
  end

  // quotient: floor(a * 2^(FRAC_BITS+1) / r^2) equals 2|v.d|/r^2 in Q(FRAC_BITS)
  logic          dv_vld;
  logic [QW-1:0] dv_q;
  logic [PW-1:0] dv_pay;

  cbb_div #(.NW(64), .DW(62), .QW(QW), .PW(PW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s6_vld_r),
    .in_num  (s6_a_r),
    .in_den  (s6_r2_r),
    .in_pay  (s6_pay_r),
    .out_vld (dv_vld),
    .out_quo (dv_q),
    .out_pay (dv_pay)
  );

  // corner deltas from the divider payload
  logic signed [32:0] p_dx, p_dy;

  assign p_dx = dv_pay[P_DX +: 33];
  assign p_dy = dv_pay[P_DY +: 33];

  // stage 7: q times d partial products, q cut into high and low 32-bit halves
  logic               s7_vld_r;
  logic [PW-1:0]      s7_pay_r;
  logic [63:0]        s7_hix_r, s7_lox_r, s7_hiy_r, s7_loy_r;
  logic [31:0]        qhi, qlo, dmx, dmy;

  always_comb begin
    qhi = 32'(dv_q >> 32);
    qlo = dv_q[31:0];
    dmx = p_dx[32] ? 32'(-p_dx) : 32'(p_dx);
    dmy = p_dy[32] ? 32'(-p_dy) : 32'(p_dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= dv_vld;
    end
    s7_hix_r <= qhi * dmx;
    s7_lox_r <= qlo * dmx;
    s7_hiy_r <= qhi * dmy;
    s7_loy_r <= qlo * dmy;
    s7_pay_r <= dv_pay;
  end

  // stage 8: combine, apply signs, new velocity
  logic               s8_vld_r;
  logic [PW-1:0]      s8_pay_r;
  logic signed [31:0] s8_cvx_r, s8_cvy_r;
  logic signed [31:0] q_vx, q_vy;
  logic signed [32:0] q_dx, q_dy;
  logic               q_qneg;
  logic [63:0]        mx, my;
  logic signed [65:0] tx, ty;

  assign q_vx   = s7_pay_r[P_VX +: 32];
  assign q_vy   = s7_pay_r[P_VY +: 32];
  assign q_dx   = s7_pay_r[P_DX +: 33];
  assign q_dy   = s7_pay_r[P_DY +: 33];
  assign q_qneg = s7_pay_r[P_QNEG];

  always_comb begin
    mx = (s7_hix_r << (32 - FRAC_BITS)) + (s7_lox_r >> FRAC_BITS);
    my = (s7_hiy_r << (32 - FRAC_BITS)) + (s7_loy_r >> FRAC_BITS);
    tx = (q_qneg != q_dx[32]) ? -66'({2'b00, mx}) : 66'({2'b00, mx});
    ty = (q_qneg != q_dy[32]) ? -66'({2'b00, my}) : 66'({2'b00, my});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
    s8_cvx_r <= sat66(66'(q_vx) + tx);
    s8_cvy_r <= sat66(66'(q_vy) + ty);
    s8_pay_r <= s7_pay_r;
  end

  // stage 9: select result, advance position, paddle term
  logic signed [31:0] r_bx, r_by, r_vx, r_vy, r_fx, r_fy, r_fvx, r_fvy, r_pvx;
  logic               r_cor, r_hit;
  logic signed [31:0] sel_x, sel_y, sel_vx, sel_vy;
  logic signed [31:0] half_pvx;

  assign r_bx  = s8_pay_r[P_BX +: 32];
  assign r_by  = s8_pay_r[P_BY +: 32];
  assign r_vx  = s8_pay_r[P_VX +: 32];
  assign r_vy  = s8_pay_r[P_VY +: 32];
  assign r_cor = s8_pay_r[P_COR];
  assign r_hit = s8_pay_r[P_HIT];
  assign r_fx  = s8_pay_r[P_FX +: 32];
  assign r_fy  = s8_pay_r[P_FY +: 32];
  assign r_fvx = s8_pay_r[P_FVX +: 32];
  assign r_fvy = s8_pay_r[P_FVY +: 32];
  assign r_pvx = s8_pay_r[P_PVX +: 32];

  always_comb begin
    if (r_cor) begin
      sel_vx = s8_cvx_r;
      sel_vy = s8_cvy_r;
      sel_x  = sat34(34'(r_bx) + 34'(s8_cvx_r));
      sel_y  = sat34(34'(r_by) + 34'(s8_cvy_r));
    end else begin
      sel_vx = r_fvx;
      sel_vy = r_fvy;
      sel_x  = r_fx;
      sel_y  = r_fy;
    end
    // divide by two, truncating toward zero
    half_pvx = $signed(r_pvx + 32'(r_pvx[31])) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= s8_vld_r;
    end
    out_new_x  <= sel_x;
    out_new_y  <= sel_y;
    out_new_vx <= (r_hit && paddle_r) ? sat34(34'(sel_vx) + 34'(half_pvx)) : sel_vx;
    out_new_vy <= sel_vy;
    out_hit    <= r_hit;
  end

  // checks
  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s6_vld_r |-> ##(QW + 3) out_strobe)
    else $error("word lost in pipeline");
  a_no_hit_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_new_vx == $past(r_vx) && out_new_vy == $past(r_vy)))
    else $error("velocity changed without a hit");

endmodule

[tb/sv/circle_box_bounce_tb.sv]
// testbench for circle_box_bounce: random and directed balls against a configured box
// depends on cbb_pkg and the circle_box_bounce rtl; scoreboard class predicts each word
`timescale 1ns / 100ps

module circle_box_bounce_tb;
  import cbb_pkg::*;

  localparam int QBITS = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               hit;
  } bounce_word_t;

  // predicts the bounce of each accepted ball and checks the words that come out
  class bounce_scoreboard;
    longint          box_cx;
    longint          box_cy;
    longint unsigned box_w;
    longint unsigned box_h;
    bit              paddle;
    bounce_word_t    pending[$];
    int              errors;

    function new();
      box_cx = 0;
      box_cy = 0;
      box_w  = 0;
      box_h  = 0;
      paddle = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_BOX_CX: box_cx = longint'($signed(d));
        REG_BOX_CY: box_cy = longint'($signed(d));
        REG_BOX_W:  box_w  = longint'({33'b0, d[30:0]});
        REG_BOX_H:  box_h  = longint'({33'b0, d[30:0]});
        REG_PADDLE: paddle = d[0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(0) - v : v;
    endfunction

    // q times d, truncated toward zero to raw units
    function longint q_scale(longint unsigned qm, bit qneg, longint d);
      longint unsigned dm;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned m;
      bit              neg;
      dm  = magn(d);
      hi  = (qm >> 32) * dm;
      lo  = (qm & 64'hFFFF_FFFF) * dm;
      m   = (hi << (32 - QBITS)) + (lo >> QBITS);
      neg = qneg != (d < 0);
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // reflect off one corner when it lies strictly inside the radius
    function bit corner_bounce(longint bx, longint by, inout longint vx, inout longint vy,
                               longint unsigned r, longint kx, longint ky,
                               inout longint nx, inout longint ny);
      longint          dx;
      longint          dy;
      longint unsigned adx;
      longint unsigned ady;
      longint unsigned r2;
      longint unsigned a;
      longint unsigned rem;
      longint unsigned qm;
      longint          dot;
      bit              qneg;
      dx  = bx - kx;
      dy  = by - ky;
      adx = magn(dx);
      ady = magn(dy);
      if (adx >= r || ady >= r) return 0;
      r2 = r * r;
      if (adx * adx + ady * ady >= r2) return 0;
      dot  = vx * dx + vy * dy;
      a    = magn(dot);
      qneg = dot > 0;
      qm   = a / r2;
      rem  = a % r2;
      for (int i = 0; i < QBITS + 1; i++) begin
        rem = rem << 1;
        qm  = qm << 1;
        if (rem >= r2) begin
          rem = rem - r2;
          qm  = qm | 64'd1;
        end
      end
      vx = clamp32(vx + q_scale(qm, qneg, dx));
      vy = clamp32(vy + q_scale(qm, qneg, dy));
      nx = clamp32(bx + vx);
      ny = clamp32(by + vy);
      return 1;
    endfunction

    function void note(longint bx, longint by, longint vx, longint vy,
                       longint unsigned r, longint pvx);
      longint       ri;
      longint       x1;
      longint       x2;
      longint       y1;
      longint       y2;
      longint       nx;
      longint       ny;
      bit           hit;
      bounce_word_t w;
      ri  = longint'(r);
      x1  = box_cx - longint'(box_w >> 1);
      x2  = box_cx + longint'(box_w >> 1);
      y1  = box_cy + longint'(box_h >> 1);
      y2  = box_cy - longint'(box_h >> 1);
      nx  = bx;
      ny  = by;
      hit = 0;
      // faces first, then corners in fixed order
      if (bx >= x1 && bx <= x2) begin
        if (by < y2 && by > y2 - ri) begin
          ny = clamp32(y2 - ri);
          vy = clamp32(-vy);
          hit = 1;
        end else if (by > y1 && by < y1 + ri) begin
          ny = clamp32(y1 + ri);
          vy = clamp32(-vy);
          hit = 1;
        end
      end else if (by >= y2 && by <= y1) begin
        if (bx < x1 && bx > x1 - ri) begin
          nx = clamp32(x1 - ri);
          vx = clamp32(-vx);
          hit = 1;
        end else if (bx > x2 && bx < x2 + ri) begin
          nx = clamp32(x2 + ri);
          vx = clamp32(-vx);
          hit = 1;
        end
      end else begin
        hit = corner_bounce(bx, by, vx, vy, r, x1, y1, nx, ny);
        if (!hit) hit = corner_bounce(bx, by, vx, vy, r, x2, y1, nx, ny);
        if (!hit) hit = corner_bounce(bx, by, vx, vy, r, x1, y2, nx, ny);
        if (!hit) hit = corner_bounce(bx, by, vx, vy, r, x2, y2, nx, ny);
      end
      if (hit && paddle) vx = clamp32(vx + pvx / 2);
      w.x   = nx[31:0];
      w.y   = ny[31:0];
      w.vx  = vx[31:0];
      w.vy  = vy[31:0];
      w.hit = hit;
      pending.push_back(w);
    endfunction

    function void check(bounce_word_t got);
      bounce_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h vx=%h vy=%h hit=%b", $time,
                 got.x, got.y, got.vx, got.vy, got.hit);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.x !== exp.x) begin
        $display("%0t: new_x expected %h actual %h", $time, exp.x, got.x);
        errors++;
      end
      if (got.y !== exp.y) begin
        $display("%0t: new_y expected %h actual %h", $time, exp.y, got.y);
        errors++;
      end
      if (got.vx !== exp.vx) begin
        $display("%0t: new_vx expected %h actual %h", $time, exp.vx, got.vx);
        errors++;
      end
      if (got.vy !== exp.vy) begin
        $display("%0t: new_vy expected %h actual %h", $time, exp.vy, got.vy);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic signed [31:0]    in_ball_x;
  logic signed [31:0]    in_ball_y;
  logic signed [31:0]    in_ball_vx;
  logic signed [31:0]    in_ball_vy;
  logic [RAD_W-1:0]      in_ball_radius;
  logic signed [31:0]    in_paddle_vx;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [31:0]           cfg_data;
  logic                  out_strobe;
  logic signed [31:0]    out_new_x;
  logic signed [31:0]    out_new_y;
  logic signed [31:0]    out_new_vx;
  logic signed [31:0]    out_new_vy;
  logic                  out_hit;

  bounce_scoreboard sb;
  bit               gaps_on;
  longint unsigned  rad_max;

  circle_box_bounce u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ball_x(in_ball_x), .in_ball_y(in_ball_y), .in_ball_vx(in_ball_vx),
    .in_ball_vy(in_ball_vy), .in_ball_radius(in_ball_radius), .in_paddle_vx(in_paddle_vx),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_strobe(out_strobe), .out_new_x(out_new_x),
    .out_new_y(out_new_y), .out_new_vx(out_new_vx), .out_new_vy(out_new_vy),
    .out_hit(out_hit)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // sample accepted balls and outgoing words
  always @(posedge clk) begin
    bounce_word_t got;
    if (rst_n && start && !busy) begin
      sb.note(longint'(in_ball_x), longint'(in_ball_y), longint'(in_ball_vx),
              longint'(in_ball_vy), longint'({33'b0, in_ball_radius}),
              longint'(in_paddle_vx));
    end
    if (rst_n && out_strobe) begin
      got.x   = out_new_x;
      got.y   = out_new_y;
      got.vx  = out_new_vx;
      got.vy  = out_new_vy;
      got.hit = out_hit;
      sb.check(got);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
                         logic [31:0] h, logic p);
    write_reg(REG_BOX_CX, cx);
    write_reg(REG_BOX_CY, cy);
    write_reg(REG_BOX_W, w);
    write_reg(REG_BOX_H, h);
    write_reg(REG_PADDLE, {31'b0, p});
  endtask

  // one ball word: optional idle gap, then hold start until accepted
  task automatic send_ball(longint bx, longint by, longint vx, longint vy,
                           longint unsigned r, longint pvx);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      start = 1'b0;
      @(negedge clk);
    end
    start          = 1'b1;
    in_ball_x      = bx[31:0];
    in_ball_y      = by[31:0];
    in_ball_vx     = vx[31:0];
    in_ball_vy     = vy[31:0];
    in_ball_radius = r[30:0];
    in_paddle_vx   = pvx[31:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic longint jitter(longint unsigned n);
    longint v;
    v = longint'($urandom_range(0, n[31:0]));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic longint speed();
    if ($urandom_range(0, 3) == 0) return longint'($signed($urandom()));
    return jitter(64'h0004_0000);
  endfunction

  // random ball aimed at a face, a corner, or anywhere
  task automatic random_ball();
    longint          hw;
    longint          hh;
    longint          bx;
    longint          by;
    longint unsigned r;
    int              kind;
    hw   = longint'(sb.box_w >> 1);
    hh   = longint'(sb.box_h >> 1);
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 15) == 0) r = longint'({32'b0, $urandom() & 32'h7fff_ffff});
    else r = longint'($urandom_range(1, rad_max[31:0]));
    if (r == 0) r = 1;
    case (kind)
      0, 1: begin
        bx = sb.box_cx + jitter(hw);
        by = $urandom_range(0, 1) ? sb.box_cy + hh : sb.box_cy - hh;
        by = by + jitter(r + 2);
      end
      2, 3: begin
        by = sb.box_cy + jitter(hh);
        bx = $urandom_range(0, 1) ? sb.box_cx + hw : sb.box_cx - hw;
        bx = bx + jitter(r + 2);
      end
      4, 5, 6, 7: begin
        bx = ($urandom_range(0, 1) ? sb.box_cx + hw : sb.box_cx - hw) + jitter(r);
        by = ($urandom_range(0, 1) ? sb.box_cy + hh : sb.box_cy - hh) + jitter(r);
      end
      default: begin
        bx = longint'($signed($urandom()));
        by = longint'($signed($urandom()));
      end
    endcase
    send_ball(sb.clamp32(bx), sb.clamp32(by), speed(), speed(), r,
              longint'($signed($urandom())));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) random_ball();
    drain();
  endtask

  initial begin
    sb             = new();
    gaps_on        = 1'b1;
    rad_max        = 64'h0008_0000;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_ball_x      = '0;
    in_ball_y      = '0;
    in_ball_vx     = '0;
    in_ball_vy     = '0;
    in_ball_radius = '0;
    in_paddle_vx   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset box (a point at the origin), then a modest box
    send_ball(0, 0, 1, 1, 1, 0);
    send_ball(100, 50, 3, -7, 200, 0);
    send_ball(64'sh7fff_ffff, -64'sh8000_0000, -64'sh8000_0000, 64'sh7fff_ffff,
              64'h7fff_ffff, 64'sh7fff_ffff);
    send_ball(-64'sh8000_0000, 64'sh7fff_ffff, 64'sh7fff_ffff, -64'sh8000_0000,
              64'h7fff_ffff, -64'sh8000_0000);
    drain();
    set_box(32'h0005_0000, 32'hfffd_0000, 32'h0008_0000, 32'h0004_0000, 1'b1);
    // bottom face, top face, left face, right face
    send_ball(64'h0005_0000, -64'h0005_8000, 64'h100, 64'h2000, 64'h0001_0000, 64'h301);
    send_ball(64'h0005_0000, -64'h0000_8000, 64'h100, -64'h2000, 64'h0001_0000, -64'h301);
    send_ball(64'h0000_8000, -64'h0003_0000, 64'h3000, 64'h10, 64'h0001_0000, 64'h7);
    send_ball(64'h0009_8000, -64'h0003_0000, -64'h3000, 64'h10, 64'h0001_0000, -64'h7);
    // each corner just inside the radius, then a near miss
    send_ball(64'h0000_c000, -64'h0000_c000, 64'h4000, -64'h4000, 64'h0001_0000, 64'h2);
    send_ball(64'h0009_4000, -64'h0000_c000, -64'h4000, -64'h4000, 64'h0001_0000, 64'h2);
    send_ball(64'h0000_c000, -64'h0005_4000, 64'h4000, 64'h4000, 64'h0001_0000, 64'h2);
    send_ball(64'h0009_4000, -64'h0005_4000, -64'h4000, 64'h4000, 64'h0001_0000, 64'h2);
    send_ball(64'h0000_4000, 64'h0000_4000, 64'h4000, 64'h4000, 64'h0001_0000, 64'h2);
    // ball far inside the box and one with huge velocity at a corner
    send_ball(64'h0005_0000, -64'h0003_0000, 64'h1, 64'h1, 64'h0000_1000, 64'h1);
    send_ball(64'h0000_c000, -64'h0000_c000, 64'sh7fff_ffff, -64'sh8000_0000,
              64'h0001_0000, 64'sh7fff_ffff);
    drain();

    random_phase(380);

    // no idle gaps here
    gaps_on = 1'b0;
    set_box(32'h0005_0000, 32'hfffd_0000, 32'h0008_0000, 32'h0004_0000, 1'b0);
    random_phase(380);
    gaps_on = 1'b1;

    // extreme box
    rad_max = 64'h4000_0000;
    set_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    random_phase(360);

    // a point box at a far corner, then a line box
    rad_max = 64'h0010_0000;
    set_box(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    random_phase(200);
    set_box(32'h0000_1234, 32'hffff_0000, 32'h0, 32'h0003_0001, 1'b1);
    random_phase(200);

    // random boxes
    for (int p = 0; p < 4; p++) begin
      rad_max = longint'($urandom_range(2, 32'h0020_0000));
      set_box($urandom() & 32'h00ff_ffff ^ ($urandom_range(0, 1) ? 32'hff00_0000 : 32'h0),
              $urandom() & 32'h00ff_ffff ^ ($urandom_range(0, 1) ? 32'hff00_0000 : 32'h0),
              $urandom() & 32'h003f_ffff, $urandom() & 32'h003f_ffff,
              1'($urandom_range(0, 1)));
      random_phase(100);
    end

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
